// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by fenwick_tree_range_sum_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ftr_pkg.sv -----
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared widths, codes and types of the Fenwick tree range sum core.
// ----------------------------------------------------------------------------
package ftr_pkg;

    localparam int OP_W   = 2;
    localparam int FLD_W  = 11;
    localparam int DATA_W = 64;
    localparam int FAC_W  = 32;
    localparam int ST_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_SCDOWN = 2'd2;
    localparam logic [OP_W-1:0] OP_SCUP   = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_DIV = 2'd2;

    // Divider request
    typedef struct packed {
        logic start;
        logic den_neg;
    } t_div_req;

endpackage

// ----- design/ftr_ram.sv -----
// ----------------------------------------------------------------------------
// ftr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ftr_div.sv -----
// ----------------------------------------------------------------------------
// ftr_div
// Signed 64 by 32 bit divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ftr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ftr_pkg::t_div_req            i_req,
    input  logic [ftr_pkg::DATA_W-1:0]   i_num,
    input  logic [ftr_pkg::FAC_W-1:0]    i_den_mag,
    output logic                         o_done,
    output logic [ftr_pkg::DATA_W-1:0]   o_quo
);

    localparam int CW = $clog2(ftr_pkg::DATA_W);

    logic                        r_busy;
    logic                        r_fin;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic                        r_neg;
    logic [ftr_pkg::FAC_W-1:0]   r_den;
    logic [ftr_pkg::FAC_W-1:0]   r_rem;
    logic [ftr_pkg::DATA_W-1:0]  r_quo;

    logic [ftr_pkg::FAC_W:0]     w_shift;
    logic                        w_ge;
    logic [ftr_pkg::FAC_W:0]     w_diff;

    // One restoring step
    always_comb begin
        w_shift = {r_rem, r_quo[ftr_pkg::DATA_W-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_req.start && r_busy && (r_cnt == CW'(ftr_pkg::DATA_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ftr_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: load magnitudes, iterate, apply the quotient sign
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_num[ftr_pkg::DATA_W-1] ^ i_req.den_neg;
            r_den <= i_den_mag;
            r_rem <= '0;
            r_quo <= i_num[ftr_pkg::DATA_W-1] ? (~i_num + 1'b1) : i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ftr_pkg::FAC_W-1:0] : w_shift[ftr_pkg::FAC_W-1:0];
            r_quo <= {r_quo[ftr_pkg::DATA_W-2:0], w_ge};
        end else if (r_fin) begin
            r_quo <= r_neg ? (~r_quo + 1'b1) : r_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- design/fenwick_tree_range_sum_core.sv -----
// ----------------------------------------------------------------------------
// fenwick_tree_range_sum_core
// Fenwick tree of 64-bit node sums in one RAM: point update, range sum,
// scale down and scale up of every node in use.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Content
// s         in   tvalid/tready      tuser operation, tdata fields
// m         out  tvalid/tready      tuser status, tdata sum_result
// cfg       in   write enable       size_in_use
//
// Update reads and writes each node on the upward path. Query reads each
// node on both prefix paths. Scale up multiplies and scale down divides
// every node in use (serial divider). All node traffic goes
// through the single RAM read and write port. After reset a clearing pass
// writes zero to all TREE_DEPTH entries, one per cycle, with o_s_tready low.
// A finished result waits until the output register is free; the next item
// is taken once it has moved there.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fenwick_tree_range_sum_core #(
    parameter int TREE_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    // [10:0] position, [21:11] range_start, [32:22] range_end,
    // [96:33] delta, [128:97] factor, rest zero
    input  logic [135:0]   i_s_tdata,
    // [1:0] operation
    input  logic [1:0]     i_s_tuser,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    // [63:0] sum_result
    output logic [63:0]    o_m_tdata,
    // [1:0] status
    output logic [1:0]     o_m_tuser,
    input  logic           i_cfg_we,
    input  logic [10:0]    i_cfg_wdata
);

    localparam int AW  = $clog2(TREE_DEPTH);
    localparam int DW  = $clog2(TREE_DEPTH + 1);
    localparam int XW  = (DW > ftr_pkg::FLD_W) ? DW : ftr_pkg::FLD_W;
    localparam int IW  = XW + 1;
    localparam int PAD = IW - ftr_pkg::FLD_W;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_UPD_RD  = 4'd2;
    localparam logic [3:0] S_UPD_WR  = 4'd3;
    localparam logic [3:0] S_QRY_RD  = 4'd4;
    localparam logic [3:0] S_QRY_ACC = 4'd5;
    localparam logic [3:0] S_SC_RD   = 4'd6;
    localparam logic [3:0] S_SC_LAT  = 4'd7;
    localparam logic [3:0] S_SC_M1   = 4'd8;
    localparam logic [3:0] S_SC_M2   = 4'd9;
    localparam logic [3:0] S_SC_MC   = 4'd10;
    localparam logic [3:0] S_SC_DIV  = 4'd11;
    localparam logic [3:0] S_SC_WR   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]                          r_state;
    logic [AW-1:0]                       r_clr;
    logic [IW-1:0]                       r_size;
    logic [ftr_pkg::OP_W-1:0]            r_op;
    logic [IW-1:0]                       r_idx;
    logic [IW-1:0]                       r_idx2;
    logic                                r_second;
    logic [ftr_pkg::DATA_W-1:0]          r_delta;
    logic [ftr_pkg::FAC_W-1:0]           r_fac;
    logic [ftr_pkg::FAC_W-1:0]           r_fmag;
    logic [ftr_pkg::DATA_W-1:0]          r_acc;
    logic [ftr_pkg::ST_W-1:0]            r_st;
    logic [ftr_pkg::DATA_W-1:0]          r_node;
    logic [ftr_pkg::DATA_W-1:0]          r_p0;
    logic [ftr_pkg::FAC_W-1:0]           r_p1;
    logic                                r_mv;
    logic [ftr_pkg::DATA_W-1:0]          r_msum;
    logic [ftr_pkg::ST_W-1:0]            r_mst;

    logic [ftr_pkg::FLD_W-1:0]           w_pos;
    logic [ftr_pkg::FLD_W-1:0]           w_rs;
    logic [ftr_pkg::FLD_W-1:0]           w_re;
    logic [ftr_pkg::DATA_W-1:0]          w_delta;
    logic [ftr_pkg::FAC_W-1:0]           w_fac;
    logic [IW-1:0]                       w_pos_x;
    logic [IW-1:0]                       w_rs_x;
    logic [IW-1:0]                       w_re_x;
    logic [IW-1:0]                       w_cfg_x;
    logic                                w_accept;
    logic [IW-1:0]                       w_low;
    logic [IW-1:0]                       w_idx_m1;
    logic [AW-1:0]                       w_addr;
    logic                                w_we;
    logic [ftr_pkg::DATA_W-1:0]          w_wdata;
    logic [ftr_pkg::DATA_W-1:0]          w_rdata;
    logic                                w_out_free;
    logic [ftr_pkg::DATA_W-1:0]          w_prod0;
    logic [ftr_pkg::FAC_W-1:0]           w_prod1;
    ftr_pkg::t_div_req                   w_div_req;
    logic                                w_div_done;
    logic [ftr_pkg::DATA_W-1:0]          w_div_quo;

    // Unpack the input transaction
    assign w_pos   = i_s_tdata[10:0];
    assign w_rs    = i_s_tdata[21:11];
    assign w_re    = i_s_tdata[32:22];
    assign w_delta = i_s_tdata[96:33];
    assign w_fac   = i_s_tdata[128:97];
    assign w_pos_x = {{PAD{1'b0}}, w_pos};
    assign w_rs_x  = {{PAD{1'b0}}, w_rs};
    assign w_re_x  = {{PAD{1'b0}}, w_re};
    assign w_cfg_x = {{PAD{1'b0}}, i_cfg_wdata};

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_mv || i_m_tready;

    // Index arithmetic and memory address
    assign w_low    = r_idx & (~r_idx + 1'b1);
    assign w_idx_m1 = r_idx - 1'b1;
    assign w_addr   = (r_state == S_CLR) ? r_clr : w_idx_m1[AW-1:0];

    // Memory write: clearing pass, update, scale write-back
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_node;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_UPD_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata + r_delta;
            end
            S_SC_WR: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Partial products of the 64 by 32 bit wrapping multiply
    assign w_prod0 = {32'b0, r_node[31:0]} * {32'b0, r_fac};
    assign w_prod1 = r_node[63:32] * r_fac;

    assign w_div_req.start   = (r_state == S_SC_LAT) && (r_op == ftr_pkg::OP_SCDOWN);
    assign w_div_req.den_neg = r_fac[ftr_pkg::FAC_W-1];

    ftr_ram #(
        .WIDTH (ftr_pkg::DATA_W),
        .DEPTH (TREE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    ftr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_num     (w_rdata),
        .i_den_mag (r_fmag),
        .o_done    (w_div_done),
        .o_quo     (w_div_quo)
    );

    // Size register with clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= IW'(TREE_DEPTH);
        end else if (i_cfg_we) begin
            if (w_cfg_x == '0) begin
                r_size <= IW'(1);
            end else if (w_cfg_x > IW'(TREE_DEPTH)) begin
                r_size <= IW'(TREE_DEPTH);
            end else begin
                r_size <= w_cfg_x;
            end
        end
    end

    // Output valid: raise when a result is loaded, drop once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_mv <= 1'b1;
        end else if (i_m_tready) begin
            r_mv <= 1'b0;
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(TREE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_s_tuser)
                            ftr_pkg::OP_UPDATE: begin
                                r_state <= (w_pos_x == '0 || w_pos_x > r_size)
                                           ? S_DONE : S_UPD_RD;
                            end
                            ftr_pkg::OP_QUERY: begin
                                r_state <= (w_rs_x == '0 || w_rs_x > r_size ||
                                            w_re_x > r_size) ? S_DONE : S_QRY_RD;
                            end
                            ftr_pkg::OP_SCDOWN: begin
                                r_state <= (w_fac == '0) ? S_DONE : S_SC_RD;
                            end
                            default: begin
                                r_state <= S_SC_RD;
                            end
                        endcase
                    end
                end
                S_UPD_RD:  r_state <= S_UPD_WR;
                S_UPD_WR: begin
                    r_state <= ((r_idx + w_low) > r_size) ? S_DONE : S_UPD_RD;
                end
                S_QRY_RD: begin
                    if (r_idx != '0) begin
                        r_state <= S_QRY_ACC;
                    end else if (r_second) begin
                        r_state <= S_DONE;
                    end
                end
                S_QRY_ACC: r_state <= S_QRY_RD;
                S_SC_RD:   r_state <= S_SC_LAT;
                S_SC_LAT: begin
                    r_state <= (r_op == ftr_pkg::OP_SCUP) ? S_SC_M1 : S_SC_DIV;
                end
                S_SC_M1:   r_state <= S_SC_M2;
                S_SC_M2:   r_state <= S_SC_MC;
                S_SC_MC:   r_state <= S_SC_WR;
                S_SC_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SC_WR;
                    end
                end
                S_SC_WR: begin
                    r_state <= (r_idx == r_size) ? S_DONE : S_SC_RD;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op     <= i_s_tuser;
                    r_delta  <= w_delta;
                    r_fac    <= w_fac;
                    r_fmag   <= w_fac[ftr_pkg::FAC_W-1] ? (~w_fac + 1'b1) : w_fac;
                    r_acc    <= '0;
                    r_second <= 1'b0;
                    r_idx2   <= w_rs_x - 1'b1;
                    unique case (i_s_tuser)
                        ftr_pkg::OP_UPDATE: begin
                            r_idx <= w_pos_x;
                            r_st  <= (w_pos_x == '0 || w_pos_x > r_size)
                                     ? ftr_pkg::ST_RANGE : ftr_pkg::ST_OK;
                        end
                        ftr_pkg::OP_QUERY: begin
                            r_idx <= w_re_x;
                            r_st  <= (w_rs_x == '0 || w_rs_x > r_size || w_re_x > r_size)
                                     ? ftr_pkg::ST_RANGE : ftr_pkg::ST_OK;
                        end
                        ftr_pkg::OP_SCDOWN: begin
                            r_idx <= IW'(1);
                            r_st  <= (w_fac == '0) ? ftr_pkg::ST_ZERO_DIV : ftr_pkg::ST_OK;
                        end
                        default: begin
                            r_idx <= IW'(1);
                            r_st  <= ftr_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_UPD_WR: r_idx <= r_idx + w_low;
            S_QRY_RD: begin
                if (r_idx == '0 && !r_second) begin
                    r_second <= 1'b1;
                    r_idx    <= r_idx2;
                end
            end
            S_QRY_ACC: begin
                r_acc <= r_second ? (r_acc - w_rdata) : (r_acc + w_rdata);
                r_idx <= r_idx - w_low;
            end
            S_SC_LAT:  r_node <= w_rdata;
            S_SC_M1:   r_p0 <= w_prod0;
            S_SC_M2:   r_p1 <= w_prod1;
            S_SC_MC: begin
                r_node <= r_p0 + {(r_p1 - (r_fac[ftr_pkg::FAC_W-1] ? r_node[31:0] : 32'b0)),
                                  32'b0};
            end
            S_SC_DIV: begin
                if (w_div_done) begin
                    r_node <= w_div_quo;
                end
            end
            S_SC_WR:   r_idx <= r_idx + 1'b1;
            S_DONE: begin
                if (w_out_free) begin
                    r_msum <= r_acc;
                    r_mst  <= r_st;
                end
            end
            default: begin
                r_p1 <= r_p1;
            end
        endcase
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_msum;
    assign o_m_tuser  = r_mst;

    // Checks
    `ASSERT_IMPL(a_size_range, i_clk, i_rst_n, 1'b1,
        (r_size != '0 && r_size <= IW'(TREE_DEPTH)), "size register out of range")
    `ASSERT_IMPL(a_walk_addr, i_clk, i_rst_n, (w_we && r_state != S_CLR),
        (r_idx != '0 && r_idx <= r_size), "node write outside the size in use")
    `ASSERT_IMPL(a_div_done, i_clk, i_rst_n, w_div_done,
        (r_state == S_SC_DIV), "divider finished outside a scale-down step")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_DONE && r_mv && !i_m_tready),
        (r_state == S_DONE), "result loaded over a pending transaction")

endmodule
